// ===== src/art_pkg.sv =====
// Shared types and constants for the aging result table.
package art_pkg;

    // Fixed field widths of the item ports and the lifetime
    localparam int ID_W   = 16;
    localparam int NOW_W  = 32;
    localparam int SLOT_W = 4;
    localparam int LIVE_W = 5;
    localparam int LIFE_W = 31;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_LIFETIME = 1'b0;
    localparam logic [LIFE_W-1:0] LIFE_RESET = 31'd60;

    typedef enum logic [1:0] {
        CMD_LOOKUP   = 2'd0,
        CMD_REGISTER = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_TICK     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_SCAN    = 2'd1,
        ST_COMMIT  = 2'd2,
        ST_DELIVER = 2'd3
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic scan_en;
        logic commit;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } ctrl_stat_t;

endpackage

// ===== src/art_ctrl.sv =====
// Sequencing state machine for the aging result table.
module art_ctrl
    import art_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  ctl
);

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through accept, scan, commit and deliver
    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        ctl          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctl.scan_en = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                ctl.commit = 1'b1;
                state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                if (stat.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/art_datapath.sv =====
// Entry storage, serial scan, update and result register of the aging result table.
module art_datapath
    import art_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         ctl,
    output ctrl_stat_t        stat,
    input  logic [1:0]        cmd,
    input  logic [ID_W-1:0]   subject_id,
    input  logic              outcome,
    input  logic [NOW_W-1:0]  now,
    input  logic [LIFE_W-1:0] lifetime,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              hit,
    output logic [SLOT_W-1:0] slot,
    output logic              accepted,
    output logic [LIVE_W-1:0] live_count,
    output logic              stored_outcome
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [NOW_W-1:0]    stamp;
        logic                outc;
    } entry_t;

    entry_t mem [ENTRIES];
    logic   valid_reg [ENTRIES];

    // Latched item
    cmd_t                cmd_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                outc_reg;
    logic [NOW_W-1:0]    now_reg;

    // Scan pipeline
    logic [CW-1:0] cnt_reg;
    logic          pipe_vld_reg;
    logic [IW-1:0] pipe_idx_reg;
    entry_t        rd_reg;

    // Scan trackers
    logic          found_reg;
    logic [IW-1:0] hit_idx_reg;
    logic          hit_outc_reg;
    logic          any_free_reg;
    logic [IW-1:0] free_idx_reg;

    logic [CW-1:0] live_reg;
    logic          out_valid_reg;
    logic          hit_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic          acc_reg;
    logic [LIVE_W-1:0] live_out_reg;
    logic          so_reg;

    logic          issue;
    logic          scan_done;
    logic          is_tick;
    logic          expired;
    logic [NOW_W-1:0] age;
    logic          do_ins;
    logic          do_rem;
    logic [IW-1:0] slot_sel;

    assign scan_done = (cnt_reg == CW'(ENTRIES));
    assign issue     = ctl.scan_en && !scan_done;
    assign is_tick   = (cmd_reg == CMD_TICK);
    assign age       = now_reg - rd_reg.stamp;
    assign expired   = valid_reg[pipe_idx_reg] && (age >= {1'b0, lifetime});
    assign do_ins    = ctl.commit && (cmd_reg == CMD_REGISTER) && !found_reg && any_free_reg;
    assign do_rem    = ctl.commit && (cmd_reg == CMD_REMOVE) && found_reg;
    assign slot_sel  = found_reg ? hit_idx_reg : free_idx_reg;

    assign stat.scan_done = scan_done;
    assign stat.out_free  = !out_valid_reg || out_ready;

    // Latch the item on accept
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            cmd_reg  <= cmd_t'(cmd);
            key_reg  <= KEY_BITS'(subject_id);
            outc_reg <= outcome;
            now_reg  <= now;
        end
    end

    // Memory: read one slot per scan cycle, write on insert
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_reg <= mem[cnt_reg[IW-1:0]];
        end
        if (do_ins)
        begin
            mem[free_idx_reg] <= '{key: key_reg, stamp: now_reg, outc: outc_reg};
        end
    end

    // Advance the scan counter and the compare stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            pipe_vld_reg <= 1'b0;
            pipe_idx_reg <= '0;
        end
        else
        begin
            if (ctl.start)
            begin
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            pipe_vld_reg <= issue;
            if (issue)
            begin
                pipe_idx_reg <= cnt_reg[IW-1:0];
            end
        end
    end

    // Track the lowest hit and the highest free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            hit_idx_reg  <= '0;
            hit_outc_reg <= 1'b0;
            any_free_reg <= 1'b0;
            free_idx_reg <= '0;
        end
        else if (ctl.start)
        begin
            found_reg    <= 1'b0;
            hit_idx_reg  <= '0;
            hit_outc_reg <= 1'b0;
            any_free_reg <= 1'b0;
            free_idx_reg <= '0;
        end
        else if (pipe_vld_reg && !is_tick)
        begin
            if (!valid_reg[pipe_idx_reg])
            begin
                any_free_reg <= 1'b1;
                free_idx_reg <= pipe_idx_reg;
            end
            else if (!found_reg && (rd_reg.key == key_reg))
            begin
                found_reg    <= 1'b1;
                hit_idx_reg  <= pipe_idx_reg;
                hit_outc_reg <= rd_reg.outc;
            end
        end
    end

    // Update valid bits: expire on tick, set on insert, clear on remove
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (pipe_vld_reg && is_tick && expired)
            begin
                valid_reg[pipe_idx_reg] <= 1'b0;
            end
            if (do_ins)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (do_rem)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end
        end
    end

    // Keep the live entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else if (do_ins)
        begin
            live_reg <= live_reg + 1'b1;
        end
        else if (do_rem || (pipe_vld_reg && is_tick && expired))
        begin
            live_reg <= live_reg - 1'b1;
        end
    end

    // Build the result on commit
    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            hit_reg <= found_reg;
            slot_reg <= SLOT_W'(slot_sel);
            acc_reg <= do_ins || do_rem;
            so_reg  <= hit_outc_reg;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            hit            <= hit_reg;
            slot           <= slot_reg;
            accepted       <= acc_reg;
            live_out_reg   <= LIVE_W'(live_reg);
            stored_outcome <= so_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign live_count = live_out_reg;

endmodule

// ===== src/aging_result_table_top.sv =====
// An accepted item goes through scan, commit and deliver to give its result;
// the next is taken once that result is loaded, held while the last is untaken;
// the serial scan reads one slot per cycle through the single entry memory port.
// Reset: valid bits and the live count clear at once, lifetime returns to 60;
// there is no clearing pass, so items are accepted right after reset.
module aging_result_table_top
    import art_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            cmd,
    input  logic [ID_W-1:0]       subject_id,
    input  logic                  outcome,
    input  logic [NOW_W-1:0]      now,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  hit,
    output logic [SLOT_W-1:0]     slot,
    output logic                  accepted,
    output logic [LIVE_W-1:0]     live_count,
    output logic                  stored_outcome,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    ctrl_cmd_t         ctl;
    ctrl_stat_t        stat;
    logic [LIFE_W-1:0] lifetime_reg;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_LIFETIME);

    // Write the lifetime register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg <= LIFE_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            lifetime_reg <= pwdata[LIFE_W-1:0];
        end
    end

    // Read back
    assign prdata = reg_sel ? {1'b0, lifetime_reg} : '0;

    art_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    art_datapath #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .cmd            (cmd),
        .subject_id     (subject_id),
        .outcome        (outcome),
        .now            (now),
        .lifetime       (lifetime_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hit            (hit),
        .slot           (slot),
        .accepted       (accepted),
        .live_count     (live_count),
        .stored_outcome (stored_outcome)
    );

endmodule
